// ----- design/pidf_pkg.sv -----
// Shared types, codes and fixed-point helpers of the PID unit with filtered derivative.
// No dependencies; every other design file uses it by scoped names.
`timescale 1ns / 1ps
package pidf_pkg;

  localparam int DW   = 32;  // data width, signed Q16.16
  localparam int FB   = 16;  // fraction bits
  localparam int DTW  = 16;  // width of a valid time step (bounded by the timeout)
  localparam int CIW  = 3;   // config index width
  localparam int ILW  = 31;  // integral limit width
  localparam int DIVN = 48;  // divider dividend / quotient width
  localparam int DIVD = 49;  // divider divisor width
  localparam int MW   = 33;  // multiplier operand width
  localparam int PW   = 2 * MW;

  typedef logic signed [DW-1:0] q_t;

  typedef enum logic [CIW-1:0] {
    CFG_GAIN_P  = 3'd0,
    CFG_GAIN_I  = 3'd1,
    CFG_GAIN_D  = 3'd2,
    CFG_SCALE   = 3'd3,
    CFG_ILIMIT  = 3'd4,
    CFG_FILTER  = 3'd5,
    CFG_TIMEOUT = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_P_MUL, S_P_WB, S_D_INIT, S_RAW_GO, S_RAW_WAIT, S_RAW_WB,
    S_ALPHA_GO, S_ALPHA_WAIT, S_ALPHA_WB, S_F_MUL, S_F_WB, S_DD_MUL, S_DD_WB,
    S_SD_MUL, S_SD_WB, S_SDD_MUL, S_SDD_WB, S_SP_MUL, S_SP_WB,
    S_I1_MUL, S_I1_WB, S_I2_MUL, S_I2_WB, S_I_GO, S_I_WAIT, S_I_WB, S_I_ADD,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_WB, OP_DINIT, OP_DIV_RAW, OP_WB_RAW,
    OP_DIV_ALPHA, OP_WB_ALPHA, OP_DIV_I, OP_WB_I, OP_IADD, OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    MS_ERR_GP, MS_RAW_ALPHA, MS_GD_FILT, MS_DRV_SC, MS_D_SC, MS_P_SC,
    MS_ERR_GI, MS_X_SC
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e msel;
  } dp_cmd_t;

  typedef struct packed {
    logic run_d;
    logic run_i;
    logic dvalid;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  // Saturate a 64-bit signed value to the data range.
  function automatic q_t sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed({{(64-DW+1){1'b0}}, {(DW-1){1'b1}}});
    lo = $signed({{(64-DW+1){1'b1}}, {(DW-1){1'b0}}});
    if (v > hi) begin
      return hi[DW-1:0];
    end else if (v < lo) begin
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Q product: shift out the fraction truncating toward zero, then saturate.
  function automatic q_t qsat(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] t;
    logic signed [PW-FB-1:0] s;
    t = prod;
    if (prod[PW-1]) begin
      t = prod + $signed({{(PW-FB){1'b0}}, {FB{1'b1}}});
    end
    s = $signed(t[PW-1:FB]);
    return sat64(64'(s));
  endfunction

endpackage

// ----- design/pidf_if.sv -----
// Valid/ready channel interfaces for the error samples and the controller results.
// Uses pidf_pkg for the data type.
`timescale 1ns / 1ps
interface pidf_in_if;
  logic          valid;
  logic          ready;
  pidf_pkg::q_t  error_in;
  logic [31:0]   now_ms;
  modport source (output valid, error_in, now_ms, input ready);
  modport sink (input valid, error_in, now_ms, output ready);
endinterface

interface pidf_out_if;
  logic         valid;
  logic         ready;
  pidf_pkg::q_t drive_out;
  pidf_pkg::q_t p_term;
  pidf_pkg::q_t i_term;
  pidf_pkg::q_t d_term;
  modport source (output valid, drive_out, p_term, i_term, d_term, input ready);
  modport sink (input valid, drive_out, p_term, i_term, d_term, output ready);
endinterface

// ----- design/pidf_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, and a divide-by-1000 unit
// built on reciprocal multiplication. Uses pidf_pkg for widths.
`timescale 1ns / 1ps
module pidf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pidf_pkg::DIVN-1:0]  num_i,
  input  logic [pidf_pkg::DIVD-1:0]  den_i,
  output logic                       busy_o,
  output logic [pidf_pkg::DIVN-1:0]  quo_o
);
  localparam int CW = $clog2(pidf_pkg::DIVN);

  logic [pidf_pkg::DIVD-1:0] rem_q, den_q;
  logic [pidf_pkg::DIVN-1:0] quo_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q;
  logic [pidf_pkg::DIVD:0]   shifted;
  logic                      ge;

  assign shifted = {rem_q, quo_q[pidf_pkg::DIVN-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(pidf_pkg::DIVN - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (shifted[pidf_pkg::DIVD-1:0] - den_q) : shifted[pidf_pkg::DIVD-1:0];
      quo_q <= {quo_q[pidf_pkg::DIVN-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

// floor(mag * dt / 1000) in five steps: split mag into 1000*qx + rx, then
// qx*dt + floor(rx*dt/1000). Each division by 1000 is a shift by three and a
// multiplication by a rounded-up reciprocal of 125, exact over these ranges.
module pidf_div1k (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pidf_pkg::DW-1:0]    mag_i,
  input  logic [pidf_pkg::DTW-1:0]   dt_i,
  output logic                       busy_o,
  output logic [pidf_pkg::DIVN-1:0]  quo_o
);
  localparam logic [28:0] RECIP_HI = 29'd274877907;  // ceil(2^35 / 125)
  localparam logic [23:0] RECIP_LO = 24'd8589935;    // ceil(2^30 / 125)

  localparam logic [2:0] STEP_QX  = 3'd0;
  localparam logic [2:0] STEP_RX  = 3'd1;
  localparam logic [2:0] STEP_PB  = 3'd2;
  localparam logic [2:0] STEP_QB  = 3'd3;
  localparam logic [2:0] STEP_SUM = 3'd4;

  logic [2:0]                   step_q;
  logic                         busy_q;
  logic [31:0]                  mag_q;
  logic [15:0]                  dt_q;
  logic [21:0]                  qx_q;
  logic [9:0]                   rx_q;
  logic [37:0]                  pa_q;
  logic [25:0]                  pb_q;
  logic [15:0]                  qb_q;
  logic [pidf_pkg::DIVN-1:0]    quo_q;
  logic [56:0]                  qx_full;
  logic [31:0]                  rx_full;
  logic [45:0]                  qb_full;

  assign qx_full = 57'(mag_q[31:3]) * 57'(RECIP_HI);
  assign rx_full = mag_q - 32'(qx_q) * 32'd1000;
  assign qb_full = 46'(pb_q[25:3]) * 46'(RECIP_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_QX;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_QX;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_SUM) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      dt_q  <= dt_i;
    end else if (busy_q) begin
      unique case (step_q)
        STEP_QX: qx_q <= qx_full[56:35];
        STEP_RX: begin
          rx_q <= rx_full[9:0];
          pa_q <= 38'(qx_q) * 38'(dt_q);
        end
        STEP_PB:  pb_q  <= 26'(rx_q) * 26'(dt_q);
        STEP_QB:  qb_q  <= qb_full[45:30];
        STEP_SUM: quo_q <= pidf_pkg::DIVN'(pa_q) + pidf_pkg::DIVN'(qb_q);
        default: ;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

// ----- design/pidf_dp.sv -----
// Datapath: configuration, controller state, shared multiplier, dividers and result register.
// Uses pidf_pkg, pidf_div and pidf_div1k; driven by command words from pidf_ctrl.
`timescale 1ns / 1ps
module pidf_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pidf_pkg::CIW-1:0]   cfg_idx_i,
  input  logic [pidf_pkg::DW-1:0]    cfg_wdata_i,
  input  pidf_pkg::q_t               error_i,
  input  logic [31:0]                now_i,
  input  pidf_pkg::dp_cmd_t          cmd_i,
  output pidf_pkg::dp_stat_t         stat_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output pidf_pkg::q_t               drive_o,
  output pidf_pkg::q_t               p_o,
  output pidf_pkg::q_t               i_o,
  output pidf_pkg::q_t               d_o
);
  localparam int DTW = pidf_pkg::DTW;
  localparam int MW  = pidf_pkg::MW;
  localparam int PW  = pidf_pkg::PW;
  localparam int DN  = pidf_pkg::DIVN;
  localparam int DD  = pidf_pkg::DIVD;
  localparam int DW  = pidf_pkg::DW;
  localparam int FB  = pidf_pkg::FB;

  // configuration
  pidf_pkg::q_t              gp_q, gi_q, gd_q, sc_q;
  logic [pidf_pkg::ILW-1:0]  ilim_q;
  logic [31:0]               filt_ms_q;
  logic [15:0]               tmo_q;

  // state across items
  logic [31:0]   prev_time_q;
  pidf_pkg::q_t  integ_q, filt_q, prev_err_q;
  logic          dvalid_q;

  // per-item working registers
  pidf_pkg::q_t          err_q, p_q, d_q, drive_q, raw_q, x_q;
  logic [DTW-1:0]        dt_q;
  logic [FB:0]           alpha_q;
  logic                  run_d_q, run_i_q, div_neg_q, div_k_q;
  logic signed [PW-1:0]  prod_q;

  // result register
  logic          out_valid_q;
  pidf_pkg::q_t  out_drive_q, out_p_q, out_i_q, out_d_q;

  // item load
  logic [31:0] dtw;
  logic        gap;
  assign dtw = now_i - prev_time_q;
  assign gap = (prev_time_q == '0) || (dtw > {16'b0, tmo_q});

  // multiplier operands
  logic signed [MW-1:0] opa, opb;
  logic signed [MW-1:0] rdiff;
  assign rdiff = $signed({raw_q[DW-1], raw_q}) - $signed({filt_q[DW-1], filt_q});

  always_comb begin
    opa = $signed({err_q[DW-1], err_q});
    opb = $signed({gp_q[DW-1], gp_q});
    unique case (cmd_i.msel)
      pidf_pkg::MS_ERR_GP: begin
        opa = $signed({err_q[DW-1], err_q});
        opb = $signed({gp_q[DW-1], gp_q});
      end
      pidf_pkg::MS_RAW_ALPHA: begin
        opa = rdiff;
        opb = $signed({{(MW-FB-1){1'b0}}, alpha_q});
      end
      pidf_pkg::MS_GD_FILT: begin
        opa = $signed({gd_q[DW-1], gd_q});
        opb = $signed({filt_q[DW-1], filt_q});
      end
      pidf_pkg::MS_DRV_SC: begin
        opa = $signed({drive_q[DW-1], drive_q});
        opb = $signed({sc_q[DW-1], sc_q});
      end
      pidf_pkg::MS_D_SC: begin
        opa = $signed({d_q[DW-1], d_q});
        opb = $signed({sc_q[DW-1], sc_q});
      end
      pidf_pkg::MS_P_SC: begin
        opa = $signed({p_q[DW-1], p_q});
        opb = $signed({sc_q[DW-1], sc_q});
      end
      pidf_pkg::MS_ERR_GI: begin
        opa = $signed({err_q[DW-1], err_q});
        opb = $signed({gi_q[DW-1], gi_q});
      end
      pidf_pkg::MS_X_SC: begin
        opa = $signed({x_q[DW-1], x_q});
        opb = $signed({sc_q[DW-1], sc_q});
      end
      default: begin
        opa = $signed({err_q[DW-1], err_q});
        opb = $signed({gp_q[DW-1], gp_q});
      end
    endcase
  end

  pidf_pkg::q_t qs;
  assign qs = pidf_pkg::qsat(prod_q);

  // divider operands
  logic signed [MW-1:0]  ediff;
  logic signed [42:0]    m_raw;
  logic [42:0]           mag_raw;
  logic [DW-1:0]         mag_x;
  logic                  div_start;
  logic                  k_start;
  logic [DN-1:0]         div_num;
  logic [DD-1:0]         div_den;
  logic                  div_neg;
  logic                  div_busy;
  logic                  k_busy;
  logic [DN-1:0]         div_quo;
  logic [DN-1:0]         k_quo;
  logic [DN-1:0]         quo;

  assign ediff   = $signed({err_q[DW-1], err_q}) - $signed({prev_err_q[DW-1], prev_err_q});
  assign m_raw   = $signed({{10{ediff[MW-1]}}, ediff}) * $signed(43'd1000);
  assign mag_raw = m_raw[42] ? 43'(-m_raw) : 43'(m_raw);
  assign mag_x   = x_q[DW-1] ? (~x_q + 1'b1) : x_q;

  always_comb begin
    div_start = 1'b0;
    k_start   = 1'b0;
    div_num   = {{(DN-43){1'b0}}, mag_raw};
    div_den   = {{(DD-DTW){1'b0}}, dt_q};
    div_neg   = m_raw[42];
    unique case (cmd_i.op)
      pidf_pkg::OP_DIV_RAW: begin
        div_start = 1'b1;
      end
      pidf_pkg::OP_DIV_ALPHA: begin
        div_start = 1'b1;
        div_num   = {dt_q, {(DN-DTW){1'b0}}};
        div_den   = {{(DD-32){1'b0}}, filt_ms_q}
                    + {{(DD-DTW-FB){1'b0}}, dt_q, {FB{1'b0}}};
        div_neg   = 1'b0;
      end
      pidf_pkg::OP_DIV_I: begin
        k_start = 1'b1;
        div_neg = x_q[DW-1];
      end
      default: ;
    endcase
  end

  pidf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // integral step: |x| * dt / 1000
  pidf_div1k u_div1k (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (k_start),
    .mag_i   (mag_x),
    .dt_i    (dt_q),
    .busy_o  (k_busy),
    .quo_o   (k_quo)
  );

  // signed quotient and integrator update
  logic signed [DN:0]  sq;
  logic signed [63:0]  isum;
  pidf_pkg::q_t        isat;
  logic signed [63:0]  lim64;
  pidf_pkg::q_t        iclamp;

  assign quo   = div_k_q ? k_quo : div_quo;
  assign sq    = div_neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign isum  = 64'(integ_q) + 64'(sq);
  assign isat  = pidf_pkg::sat64(isum);
  assign lim64 = $signed({{(64-pidf_pkg::ILW){1'b0}}, ilim_q});

  always_comb begin
    iclamp = isat;
    if (64'(isat) < -lim64) begin
      iclamp = DW'(-lim64);
    end else if (64'(isat) > lim64) begin
      iclamp = DW'(lim64);
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q      <= '0;
      gi_q      <= '0;
      gd_q      <= '0;
      sc_q      <= DW'(1 << FB);
      ilim_q    <= '0;
      filt_ms_q <= 32'(8 << FB);
      tmo_q     <= 16'd6;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidf_pkg::CFG_GAIN_P:  gp_q      <= cfg_wdata_i;
        pidf_pkg::CFG_GAIN_I:  gi_q      <= cfg_wdata_i;
        pidf_pkg::CFG_GAIN_D:  gd_q      <= cfg_wdata_i;
        pidf_pkg::CFG_SCALE:   sc_q      <= cfg_wdata_i;
        pidf_pkg::CFG_ILIMIT:  ilim_q    <= cfg_wdata_i[pidf_pkg::ILW-1:0];
        pidf_pkg::CFG_FILTER:  filt_ms_q <= cfg_wdata_i;
        pidf_pkg::CFG_TIMEOUT: tmo_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // state kept between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      integ_q     <= '0;
      filt_q      <= '0;
      prev_err_q  <= '0;
      dvalid_q    <= 1'b0;
      run_d_q     <= 1'b0;
      run_i_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (cmd_i.op == pidf_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        pidf_pkg::OP_LOAD: begin
          prev_time_q <= now_i;
          run_d_q     <= (gd_q != '0) && !gap && (dtw != '0);
          run_i_q     <= (gi_q != '0) && !gap && (dtw != '0);
          if (gap) begin
            integ_q  <= '0;
            dvalid_q <= 1'b0;
          end
        end
        pidf_pkg::OP_DINIT: begin
          filt_q   <= '0;
          dvalid_q <= 1'b1;
        end
        pidf_pkg::OP_WB: begin
          if (cmd_i.msel == pidf_pkg::MS_RAW_ALPHA) begin
            filt_q     <= pidf_pkg::sat64(64'(filt_q) + 64'(qs));
            prev_err_q <= err_q;
          end
        end
        pidf_pkg::OP_WB_I: integ_q <= iclamp;
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pidf_pkg::OP_MUL) begin
      prod_q <= opa * opb;
    end
    if (div_start || k_start) begin
      div_neg_q <= div_neg;
      div_k_q   <= k_start;
    end
    unique case (cmd_i.op)
      pidf_pkg::OP_LOAD: begin
        err_q <= error_i;
        dt_q  <= gap ? '0 : dtw[DTW-1:0];
        d_q   <= '0;
      end
      pidf_pkg::OP_DINIT: raw_q <= '0;
      pidf_pkg::OP_WB_RAW: raw_q <= pidf_pkg::sat64(64'(sq));
      pidf_pkg::OP_WB_ALPHA: alpha_q <= div_quo[FB:0];
      pidf_pkg::OP_WB: begin
        unique case (cmd_i.msel)
          pidf_pkg::MS_ERR_GP: begin
            p_q     <= qs;
            drive_q <= qs;
          end
          pidf_pkg::MS_GD_FILT: begin
            d_q     <= qs;
            drive_q <= pidf_pkg::sat64(64'(p_q) + 64'(qs));
          end
          pidf_pkg::MS_DRV_SC: drive_q <= qs;
          pidf_pkg::MS_D_SC:   d_q     <= qs;
          pidf_pkg::MS_P_SC:   p_q     <= qs;
          pidf_pkg::MS_ERR_GI: x_q     <= qs;
          pidf_pkg::MS_X_SC:   x_q     <= qs;
          default: ;
        endcase
      end
      pidf_pkg::OP_IADD: drive_q <= pidf_pkg::sat64(64'(drive_q) + 64'(integ_q));
      pidf_pkg::OP_OUT: begin
        out_drive_q <= drive_q;
        out_p_q     <= p_q;
        out_i_q     <= integ_q;
        out_d_q     <= d_q;
      end
      default: ;
    endcase
  end

  assign stat_o = '{run_d:    run_d_q,
                    run_i:    run_i_q,
                    dvalid:   dvalid_q,
                    div_busy: div_busy || k_busy,
                    out_free: !out_valid_q || out_ready_i};

  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign p_o         = out_p_q;
  assign i_o         = out_i_q;
  assign d_o         = out_d_q;
endmodule

// ----- design/pidf_ctrl.sv -----
// Sequencer for the PID unit: walks one sample through the datapath step by step.
// Uses pidf_pkg for states, commands and status.
`timescale 1ns / 1ps
module pidf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pidf_pkg::dp_stat_t stat_i,
  output pidf_pkg::dp_cmd_t  cmd_o
);
  pidf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pidf_pkg::S_IDLE:       if (in_valid_i) state_d = pidf_pkg::S_P_MUL;
      pidf_pkg::S_P_MUL:      state_d = pidf_pkg::S_P_WB;
      pidf_pkg::S_P_WB: begin
        priority if (!stat_i.run_d) state_d = pidf_pkg::S_SD_MUL;
        else if (!stat_i.dvalid)    state_d = pidf_pkg::S_D_INIT;
        else                        state_d = pidf_pkg::S_RAW_GO;
      end
      pidf_pkg::S_D_INIT:     state_d = pidf_pkg::S_ALPHA_GO;
      pidf_pkg::S_RAW_GO:     state_d = pidf_pkg::S_RAW_WAIT;
      pidf_pkg::S_RAW_WAIT:   if (!stat_i.div_busy) state_d = pidf_pkg::S_RAW_WB;
      pidf_pkg::S_RAW_WB:     state_d = pidf_pkg::S_ALPHA_GO;
      pidf_pkg::S_ALPHA_GO:   state_d = pidf_pkg::S_ALPHA_WAIT;
      pidf_pkg::S_ALPHA_WAIT: if (!stat_i.div_busy) state_d = pidf_pkg::S_ALPHA_WB;
      pidf_pkg::S_ALPHA_WB:   state_d = pidf_pkg::S_F_MUL;
      pidf_pkg::S_F_MUL:      state_d = pidf_pkg::S_F_WB;
      pidf_pkg::S_F_WB:       state_d = pidf_pkg::S_DD_MUL;
      pidf_pkg::S_DD_MUL:     state_d = pidf_pkg::S_DD_WB;
      pidf_pkg::S_DD_WB:      state_d = pidf_pkg::S_SD_MUL;
      pidf_pkg::S_SD_MUL:     state_d = pidf_pkg::S_SD_WB;
      pidf_pkg::S_SD_WB:      state_d = pidf_pkg::S_SDD_MUL;
      pidf_pkg::S_SDD_MUL:    state_d = pidf_pkg::S_SDD_WB;
      pidf_pkg::S_SDD_WB:     state_d = pidf_pkg::S_SP_MUL;
      pidf_pkg::S_SP_MUL:     state_d = pidf_pkg::S_SP_WB;
      pidf_pkg::S_SP_WB:      state_d = stat_i.run_i ? pidf_pkg::S_I1_MUL : pidf_pkg::S_OUT;
      pidf_pkg::S_I1_MUL:     state_d = pidf_pkg::S_I1_WB;
      pidf_pkg::S_I1_WB:      state_d = pidf_pkg::S_I2_MUL;
      pidf_pkg::S_I2_MUL:     state_d = pidf_pkg::S_I2_WB;
      pidf_pkg::S_I2_WB:      state_d = pidf_pkg::S_I_GO;
      pidf_pkg::S_I_GO:       state_d = pidf_pkg::S_I_WAIT;
      pidf_pkg::S_I_WAIT:     if (!stat_i.div_busy) state_d = pidf_pkg::S_I_WB;
      pidf_pkg::S_I_WB:       state_d = pidf_pkg::S_I_ADD;
      pidf_pkg::S_I_ADD:      state_d = pidf_pkg::S_OUT;
      pidf_pkg::S_OUT:        if (stat_i.out_free) state_d = pidf_pkg::S_IDLE;
      default:                state_d = pidf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{op: pidf_pkg::OP_NONE, msel: pidf_pkg::MS_ERR_GP};
    in_ready_o = 1'b0;
    unique case (state_q)
      pidf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = pidf_pkg::OP_LOAD;
      end
      pidf_pkg::S_P_MUL:    cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_ERR_GP};
      pidf_pkg::S_P_WB:     cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_ERR_GP};
      pidf_pkg::S_D_INIT:   cmd_o.op = pidf_pkg::OP_DINIT;
      pidf_pkg::S_RAW_GO:   cmd_o.op = pidf_pkg::OP_DIV_RAW;
      pidf_pkg::S_RAW_WB:   cmd_o.op = pidf_pkg::OP_WB_RAW;
      pidf_pkg::S_ALPHA_GO: cmd_o.op = pidf_pkg::OP_DIV_ALPHA;
      pidf_pkg::S_ALPHA_WB: cmd_o.op = pidf_pkg::OP_WB_ALPHA;
      pidf_pkg::S_F_MUL:    cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_RAW_ALPHA};
      pidf_pkg::S_F_WB:     cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_RAW_ALPHA};
      pidf_pkg::S_DD_MUL:   cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_GD_FILT};
      pidf_pkg::S_DD_WB:    cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_GD_FILT};
      pidf_pkg::S_SD_MUL:   cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_DRV_SC};
      pidf_pkg::S_SD_WB:    cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_DRV_SC};
      pidf_pkg::S_SDD_MUL:  cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_D_SC};
      pidf_pkg::S_SDD_WB:   cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_D_SC};
      pidf_pkg::S_SP_MUL:   cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_P_SC};
      pidf_pkg::S_SP_WB:    cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_P_SC};
      pidf_pkg::S_I1_MUL:   cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_ERR_GI};
      pidf_pkg::S_I1_WB:    cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_ERR_GI};
      pidf_pkg::S_I2_MUL:   cmd_o = '{op: pidf_pkg::OP_MUL, msel: pidf_pkg::MS_X_SC};
      pidf_pkg::S_I2_WB:    cmd_o = '{op: pidf_pkg::OP_WB,  msel: pidf_pkg::MS_X_SC};
      pidf_pkg::S_I_GO:     cmd_o.op = pidf_pkg::OP_DIV_I;
      pidf_pkg::S_I_WB:     cmd_o.op = pidf_pkg::OP_WB_I;
      pidf_pkg::S_I_ADD:    cmd_o.op = pidf_pkg::OP_IADD;
      pidf_pkg::S_OUT:      if (stat_i.out_free) cmd_o.op = pidf_pkg::OP_OUT;
      default: ;
    endcase
  end
endmodule

// ----- design/pid_with_filtered_derivative_unit.sv -----
// Top level of the PID unit with low-pass filtered derivative and clamped integrator.
// Depends on pidf_pkg, pidf_if, pidf_ctrl, pidf_dp (which holds pidf_div and pidf_div1k).
//
//   port         dir  kind           carries
//   in_i         in   valid/ready    error_in (Q16.16), now_ms (ms timestamp)
//   out_o        out  valid/ready    drive_out, p_term, i_term, d_term (Q16.16)
//   cfg_*        in   write strobe   seven registers, index 0..6, no read-back
//
// One sample at a time. A sample with derivative and integral work spends most of
// its time in two passes through the restoring divider (raw derivative, filter
// coefficient); the integral step divides by 1000 by reciprocal multiplication
// in five steps.
// Reset clears the sequencer, the stored time, integrator and filter state, and sets
// the configuration to its defaults at once; no clearing pass. A finished result waits
// in the output register; the next sample is taken as soon as that result is parked,
// and only a stalled output holds the sequencer in its final step.
`timescale 1ns / 1ps
module pid_with_filtered_derivative_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pidf_pkg::CIW-1:0] cfg_idx_i,
  input  logic [pidf_pkg::DW-1:0]  cfg_wdata_i,
  pidf_in_if.sink                  in_i,
  pidf_out_if.source               out_o
);
  pidf_pkg::dp_cmd_t  cmd;
  pidf_pkg::dp_stat_t stat;

  // sequencer: one step of the sample's work per state
  pidf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic, state and the output register
  pidf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .error_i     (in_i.error_in),
    .now_i       (in_i.now_ms),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .drive_o     (out_o.drive_out),
    .p_o         (out_o.p_term),
    .i_o         (out_o.i_term),
    .d_o         (out_o.d_term)
  );
endmodule

// ----- design/pidf_checker.sv -----
// Port-level checks for the PID unit, attached to the top level by bind.
// Depends on pidf_pkg and pid_with_filtered_derivative_unit.
`timescale 1ns / 1ps
module pidf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input pidf_pkg::q_t drive_i,
  input pidf_pkg::q_t p_t_i,
  input pidf_pkg::q_t i_t_i,
  input pidf_pkg::q_t d_t_i
);
  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_i) && $stable(p_t_i)
                                    && $stable(i_t_i) && $stable(d_t_i))
    else $error("stalled result changed");

  // one sample in flight: no input transfer right after another
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while busy");

  // parking a result frees the unit for the next sample
  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("unit not ready after result parked");
endmodule

bind pid_with_filtered_derivative_unit pidf_checker u_pidf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive_out),
  .p_t_i       (out_o.p_term),
  .i_t_i       (out_o.i_term),
  .d_t_i       (out_o.d_term)
);
